// ===== design/render_qos_rate_estimator_defines.svh =====
// assertion macros for the render qos rate estimator
`ifndef RENDER_QOS_RATE_ESTIMATOR_DEFINES_SVH
`define RENDER_QOS_RATE_ESTIMATOR_DEFINES_SVH

// same-cycle implication
`define RQE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqe check failed");

// next-cycle implication
`define RQE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqe check failed");

`endif

// ===== design/rqe_pkg.sv =====
// shared constants and helpers of the render qos rate estimator
package rqe_pkg;
   localparam int TIME_WIDTH_DEFAULT = 48;
   localparam int FIFO_DEPTH = 4;
   localparam int DIV_STEPS = 32;
   localparam logic [31:0] RATE_ONE = 32'h0001_0000;
   localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;
   localparam logic [31:0] PROP_NUM = 32'd65536000;
   localparam logic [12:0] PROP_LOW = 13'd200;
   localparam logic [12:0] PROP_HIGH = 13'd5000;
   localparam int WIN_PLAIN_LOG = 3;
   localparam int WIN_FAST_LOG = 2;
   localparam int WIN_SLOW_LOG = 4;
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   typedef logic [12:0] prop_type;

   function automatic prop_type clamp_prop(input logic [31:0] q);
      prop_type r;
      if (q < 32'(PROP_LOW)) begin
         r = PROP_LOW;
      end else if (q > 32'(PROP_HIGH)) begin
         r = PROP_HIGH;
      end else begin
         r = q[12:0];
      end
      return r;
   endfunction
endpackage

// ===== design/rqe_front.sv =====
// front end: accepts samples and works out jitter, duration and side times
module rqe_front #(
   parameter int TIME_WIDTH = rqe_pkg::TIME_WIDTH_DEFAULT,
   localparam int TW = TIME_WIDTH,
   localparam int QW = 5 * TIME_WIDTH + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [TW-1:0] sst,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_kind,
   input  logic signed [TW-1:0] req_start,
   input  logic signed [TW-1:0] req_stop,
   input  logic signed [TW-1:0] req_now,
   input  logic                 q_full,
   output logic                 q_push,
   output logic [QW-1:0]        q_data
);
   typedef enum logic [2:0] {F_IDLE, F_JIT, F_DUR, F_SIDE, F_PUSH} fstate_type;

   fstate_type state_ff;
   logic kind_ff, famine_ff;
   logic signed [TW-1:0] start_ff, stop_ff, now_ff, d1_ff, jit_ff, dur_ff;
   logic signed [TW-1:0] entered_ff, left_ff, late_ff;
   logic signed [TW-1:0] sum, entered_c, left_c, late_c;

   function automatic logic signed [TW-1:0] sat_fix(input logic signed [TW:0] d);
      logic signed [TW-1:0] r;
      if (d[TW] != d[TW-1]) begin
         r = d[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
      end else begin
         r = d[TW-1:0];
      end
      return r;
   endfunction

   always_comb begin
      sum = start_ff + jit_ff;
      if (jit_ff[TW-1]) begin
         entered_c = sum[TW-1] ? '0 : sum;
         left_c = start_ff;
         late_c = sum[TW-1] ? -start_ff : jit_ff;
      end else begin
         entered_c = sat_fix({start_ff[TW-1], start_ff} + {jit_ff[TW-1], jit_ff});
         left_c = entered_c;
         late_c = sat_fix({jit_ff[TW-1], jit_ff} + {dur_ff[TW-1], dur_ff});
      end
   end

   assign req_tready = (state_ff == F_IDLE);
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_data = {start_ff[TW-2:0], late_ff, left_ff, entered_ff, dur_ff, famine_ff, kind_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_tvalid) begin
                  kind_ff <= req_kind;
                  start_ff <= req_start;
                  stop_ff <= req_stop;
                  now_ff <= req_now;
                  state_ff <= F_JIT;
               end
            end
            F_JIT: begin
               d1_ff <= sat_fix({now_ff[TW-1], now_ff} - {sst[TW-1], sst});
               if (kind_ff == rqe_pkg::KIND_RESET) begin
                  state_ff <= F_PUSH;
               end else if (start_ff[TW-1]) begin
                  state_ff <= F_IDLE;
               end else begin
                  state_ff <= F_DUR;
               end
            end
            F_DUR: begin
               jit_ff <= sat_fix({d1_ff[TW-1], d1_ff} - {start_ff[TW-1], start_ff});
               dur_ff <= (stop_ff > start_ff) ? stop_ff - start_ff : '0;
               state_ff <= F_SIDE;
            end
            F_SIDE: begin
               entered_ff <= entered_c;
               left_ff <= left_c;
               late_ff <= late_c;
               famine_ff <= !jit_ff[TW-1] && (jit_ff != '0);
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule

// ===== design/rqe_fifo.sv =====
// short queue between front and back
module rqe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rqe_pkg::FIFO_DEPTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] count_ff;

   assign full = (count_ff == (AW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

// ===== design/rqe_div.sv =====
// shared restoring divider, one quotient bit per cycle
module rqe_div #(
   parameter int TIME_WIDTH = rqe_pkg::TIME_WIDTH_DEFAULT,
   localparam int TW = TIME_WIDTH,
   localparam int STEPS = rqe_pkg::DIV_STEPS,
   localparam int CW = $clog2(STEPS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [TW-1:0]    rem_init,
   input  logic [STEPS-1:0] low_bits,
   input  logic [TW-1:0]    den,
   output logic             done,
   output logic [STEPS-1:0] quot
);
   logic [TW-1:0] rem_ff, den_ff;
   logic [STEPS-1:0] low_ff, quot_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [TW:0] sh, diff;
   logic take;

   assign sh = {rem_ff, low_ff[STEPS-1]};
   assign diff = sh - {1'b0, den_ff};
   assign take = (sh >= {1'b0, den_ff});
   assign done = done_ff;
   assign quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= rem_init;
            low_ff <= low_bits;
            den_ff <= den;
         end else if (busy_ff) begin
            rem_ff <= take ? diff[TW-1:0] : sh[TW-1:0];
            quot_ff <= {quot_ff[STEPS-2:0], take};
            low_ff <= {low_ff[STEPS-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// ===== design/rqe_back.sv =====
// back end: running averages, rate, proportion and result register
module rqe_back #(
   parameter int TIME_WIDTH = rqe_pkg::TIME_WIDTH_DEFAULT,
   localparam int TW = TIME_WIDTH,
   localparam int QW = 5 * TIME_WIDTH + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  logic [QW-1:0]        q_data,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_famine,
   output rqe_pkg::prop_type    rsp_proportion,
   output logic signed [TW-1:0] rsp_lateness,
   output logic [TW-2:0]        rsp_timestamp
);
   typedef enum logic [3:0] {
      B_IDLE, B_PT, B_APT, B_RCHK, B_RWAIT, B_RAVG, B_FIN, B_PWAIT, B_EMIT
   } bstate_type;

   bstate_type state_ff;
   logic [QW-1:0] ent_ff;
   logic e_rst, e_famine;
   logic signed [TW-1:0] e_dur, e_entered, e_left, e_late;
   logic [TW-2:0] e_start;
   logic signed [TW-1:0] last_leave_ff, avg_dur_ff, avg_pt_ff, pt_ff;
   logic [31:0] avg_rate_ff, rate_ff;
   logic rate_valid_ff, had_last_ff;
   rqe_pkg::prop_type prop_ff;
   logic rsp_valid_ff, famine_ff;
   rqe_pkg::prop_type out_prop_ff;
   logic signed [TW-1:0] out_late_ff;
   logic [TW-2:0] out_ts_ff;
   logic div_go_ff, div_done;
   logic [TW-1:0] div_rem_ff, div_den_ff;
   logic [31:0] div_low_ff, div_quot;
   logic [35:0] ravg_fast, ravg_slow;
   logic rate_zero, rate_sat, div_go_in, rsp_valid_in;

   assign {e_start, e_late, e_left, e_entered, e_dur, e_famine, e_rst} = ent_ff;

   function automatic logic [TW-1:0] run8(input logic [TW-1:0] avg, input logic [TW-1:0] val);
      logic [TW+2:0] s;
      s = {3'b0, val} + {avg, 3'b0} - {3'b0, avg};
      return s[TW+2:rqe_pkg::WIN_PLAIN_LOG];
   endfunction

   assign ravg_fast = 36'(rate_ff) + {2'b0, avg_rate_ff, 2'b0} - 36'(avg_rate_ff);
   assign ravg_slow = 36'(rate_ff) + {avg_rate_ff, 4'b0} - 36'(avg_rate_ff);

   assign rate_zero = avg_dur_ff[TW-1] || avg_dur_ff == '0 || avg_pt_ff[TW-1] || avg_pt_ff == '0;
   // quotient of the rate would not fit 16 integer bits
   assign rate_sat = ({16'b0, avg_pt_ff} >= {avg_dur_ff, 16'b0});
   assign div_go_in = ((state_ff == B_RCHK) && !rate_zero && !rate_sat) ||
                      ((state_ff == B_FIN) && rate_valid_ff && (avg_rate_ff != '0));
   assign rsp_valid_in = (state_ff == B_EMIT) || (rsp_valid_ff && !rsp_tready);

   assign q_pop = (state_ff == B_IDLE) && !q_empty;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_famine = famine_ff;
   assign rsp_proportion = out_prop_ff;
   assign rsp_lateness = out_late_ff;
   assign rsp_timestamp = out_ts_ff;

   rqe_div #(.TIME_WIDTH(TIME_WIDTH)) u_div (
      .clock(clock), .reset(reset), .start(div_go_ff), .rem_init(div_rem_ff),
      .low_bits(div_low_ff), .den(div_den_ff), .done(div_done), .quot(div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         last_leave_ff <= '1;
         avg_dur_ff <= '1;
         avg_pt_ff <= '1;
         avg_rate_ff <= '0;
         rate_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  ent_ff <= q_data;
                  state_ff <= B_PT;
               end
            end
            B_PT: begin
               if (e_rst == rqe_pkg::KIND_RESET) begin
                  last_leave_ff <= '1;
                  avg_dur_ff <= '1;
                  avg_pt_ff <= '1;
                  avg_rate_ff <= '0;
                  rate_valid_ff <= 1'b0;
                  state_ff <= B_IDLE;
               end else begin
                  had_last_ff <= !last_leave_ff[TW-1];
                  if (!last_leave_ff[TW-1]) begin
                     pt_ff <= (e_entered > last_leave_ff) ? e_entered - last_leave_ff : '0;
                  end else begin
                     pt_ff <= avg_pt_ff;
                  end
                  avg_dur_ff <= avg_dur_ff[TW-1] ? e_dur : run8(avg_dur_ff, e_dur);
                  state_ff <= B_APT;
               end
            end
            B_APT: begin
               avg_pt_ff <= (avg_pt_ff[TW-1] || pt_ff[TW-1]) ? pt_ff : run8(avg_pt_ff, pt_ff);
               last_leave_ff <= e_left;
               state_ff <= had_last_ff ? B_RCHK : B_FIN;
            end
            B_RCHK: begin
               if (rate_zero) begin
                  rate_ff <= '0;
                  state_ff <= B_RAVG;
               end else if (rate_sat) begin
                  rate_ff <= rqe_pkg::RATE_MAX;
                  state_ff <= B_RAVG;
               end else begin
                  div_rem_ff <= TW'(avg_pt_ff[TW-1:16]);
                  div_low_ff <= {avg_pt_ff[15:0], 16'b0};
                  div_den_ff <= avg_dur_ff;
                  state_ff <= B_RWAIT;
               end
            end
            B_RWAIT: begin
               if (div_done) begin
                  rate_ff <= div_quot;
                  state_ff <= B_RAVG;
               end
            end
            B_RAVG: begin
               if (!rate_valid_ff) begin
                  avg_rate_ff <= rate_ff;
                  rate_valid_ff <= 1'b1;
               end else if (rate_ff > rqe_pkg::RATE_ONE) begin
                  avg_rate_ff <= ravg_fast[33:rqe_pkg::WIN_FAST_LOG];
               end else begin
                  avg_rate_ff <= ravg_slow[35:rqe_pkg::WIN_SLOW_LOG];
               end
               state_ff <= B_FIN;
            end
            B_FIN: begin
               if (!rate_valid_ff) begin
                  state_ff <= B_IDLE;
               end else if (avg_rate_ff == '0) begin
                  prop_ff <= rqe_pkg::PROP_HIGH;
                  state_ff <= B_EMIT;
               end else begin
                  div_rem_ff <= '0;
                  div_low_ff <= rqe_pkg::PROP_NUM;
                  div_den_ff <= TW'(avg_rate_ff);
                  state_ff <= B_PWAIT;
               end
            end
            B_PWAIT: begin
               if (div_done) begin
                  prop_ff <= rqe_pkg::clamp_prop(div_quot);
                  state_ff <= B_EMIT;
               end
            end
            B_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  famine_ff <= e_famine;
                  out_prop_ff <= prop_ff;
                  out_late_ff <= e_late;
                  out_ts_ff <= e_start;
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule

// ===== design/render_qos_rate_estimator.sv =====
// top level of the render qos rate estimator
//
//   channel  direction  tdata (low bit up)                        tuser
//   req      in         start_time, stop_time, now_time           kind
//   rsp      out        proportion, lateness, timestamp           famine
//   csr      in         stream_start_time                         -
//
// front takes one word at a time and drops a sample with a negative start before the queue
// in the back a reset word only clears the statistics, and a sample with a result may wait
// on the 32-step divider shared by the rate and the proportion
// reset is synchronous and clears all statistics; no clearing pass
// a stalled rsp holds its word while the front keeps filling the 4-word queue
`include "render_qos_rate_estimator_defines.svh"
module render_qos_rate_estimator #(
   parameter int TIME_WIDTH = rqe_pkg::TIME_WIDTH_DEFAULT,
   localparam int TW = TIME_WIDTH,
   localparam int IN_W = ((3 * TIME_WIDTH + 7) / 8) * 8,
   localparam int OUT_W = ((2 * TIME_WIDTH + 12 + 7) / 8) * 8,
   localparam int QW = 5 * TIME_WIDTH + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,   // start_time, stop_time, now_time
   input  logic             req_tuser,   // kind
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata,   // proportion, lateness, timestamp
   output logic             rsp_tuser,   // famine
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TW-1:0]    csr_data
);
   logic signed [TW-1:0] sst_ff;
   logic q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_wdata, q_rdata;
   rqe_pkg::prop_type prop;
   logic signed [TW-1:0] late;
   logic [TW-2:0] ts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sst_ff <= '0;
      end else if (csr_valid) begin
         sst_ff <= csr_data;
      end
   end

   rqe_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
      .clock(clock), .reset(reset), .sst(sst_ff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_kind(req_tuser),
      .req_start(req_tdata[TW-1:0]), .req_stop(req_tdata[2*TW-1:TW]),
      .req_now(req_tdata[3*TW-1:2*TW]),
      .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
   );

   rqe_fifo #(.WIDTH(QW), .DEPTH(rqe_pkg::FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
   );

   rqe_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_famine(rsp_tuser),
      .rsp_proportion(prop), .rsp_lateness(late), .rsp_timestamp(ts)
   );

   assign rsp_tdata = OUT_W'({ts, late, prop});

   `RQE_ASSERT_IMP(a_no_overfill, clock, reset, q_push, !q_full)
   `RQE_ASSERT_IMP(a_no_underrun, clock, reset, q_pop, !q_empty)
   `RQE_ASSERT_NXT(a_push_lands, clock, reset, q_push, !q_empty)
   `RQE_ASSERT_IMP(a_prop_range, clock, reset, rsp_tvalid,
      prop >= rqe_pkg::PROP_LOW && prop <= rqe_pkg::PROP_HIGH)
endmodule
